/* src/cnrf_pkg.sv */
// Shared types and constants of the column nearest range finder.
// Used by the channel interfaces, the square root pipeline and the top level.
package cnrf_pkg;

  localparam int COL_W      = 10;
  localparam int RANGE_W    = 16;
  localparam int SQ_W       = 2 * RANGE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EXT_W      = 13;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = 5;
  localparam int CNT_W      = FIFO_AW + 1;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MAX = 2'd3;

  localparam logic [RANGE_W-1:0]        RANGE_MIN_RST  = 16'd500;
  localparam logic [RANGE_W-1:0]        RANGE_MAX_RST  = 16'd10000;
  localparam logic signed [RANGE_W-1:0] HEIGHT_MIN_RST = 16'sd50;
  localparam logic signed [RANGE_W-1:0] HEIGHT_MAX_RST = 16'sd1000;

  typedef struct packed {
    logic [SQ_W-1:0] min_sq;
    logic            found;
  } cnrf_entry_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             found;
  } cnrf_tag_t;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [RANGE_W-1:0] range_mm;
    logic               range_valid;
  } cnrf_res_t;

endpackage

/* src/cnrf_ifs.sv */
// Valid/ready channel interfaces: point input, range result and register writes.
// Depends on cnrf_pkg for field widths.
interface cnrf_in_if #(parameter int COORD_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  point_x;
  logic signed [COORD_BITS-1:0]  point_y;
  logic signed [COORD_BITS-1:0]  point_z;
  logic [cnrf_pkg::COL_W-1:0]    column_index;
  logic                          first_row;
  logic                          last_row;

  modport source(output valid, point_x, point_y, point_z, column_index, first_row, last_row,
                 input ready);
  modport sink(input valid, point_x, point_y, point_z, column_index, first_row, last_row,
               output ready);
endinterface

interface cnrf_out_if;
  logic                         valid;
  logic                         ready;
  logic [cnrf_pkg::COL_W-1:0]   out_column;
  logic [cnrf_pkg::RANGE_W-1:0] range_mm;
  logic                         range_valid;

  modport source(output valid, out_column, range_mm, range_valid, input ready);
  modport sink(input valid, out_column, range_mm, range_valid, output ready);
endinterface

interface cnrf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cnrf_pkg::CFG_IDX_W-1:0]  index;
  logic [cnrf_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* src/cnrf_isqrt.sv */
// Pipelined floor square root of a 32-bit value, one result bit per stage.
// Depends on cnrf_pkg; carries a column tag alongside each value.
module cnrf_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [cnrf_pkg::SQ_W-1:0]    in_val,
  input  cnrf_pkg::cnrf_tag_t          in_tag,
  output logic                         out_vld,
  output logic [cnrf_pkg::RANGE_W-1:0] out_root,
  output cnrf_pkg::cnrf_tag_t          out_tag
);

  localparam int STEPS = cnrf_pkg::RANGE_W;
  localparam int REM_W = cnrf_pkg::RANGE_W + 2;
  localparam int SH_W  = REM_W + 2;

  logic                         vld_r  [0:STEPS];
  logic [cnrf_pkg::SQ_W-1:0]    rad_r  [0:STEPS];
  logic [REM_W-1:0]             rem_r  [0:STEPS];
  logic [cnrf_pkg::RANGE_W-1:0] root_r [0:STEPS];
  cnrf_pkg::cnrf_tag_t          tag_r  [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    rad_r[0]  <= in_val;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    tag_r[0]  <= in_tag;
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] trial;
    logic            ge;

    assign rem_sh = {rem_r[k-1], rad_r[k-1][cnrf_pkg::SQ_W-1 -: 2]};
    assign trial  = SH_W'({root_r[k-1], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      rad_r[k]  <= {rad_r[k-1][cnrf_pkg::SQ_W-3:0], 2'b00};
      rem_r[k]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r[k] <= {root_r[k-1][cnrf_pkg::RANGE_W-2:0], ge};
      tag_r[k]  <= tag_r[k-1];
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign out_root = root_r[STEPS];
  assign out_tag  = tag_r[STEPS];

endmodule

/* src/column_nearest_range_finder_core.sv */
// Top level of the column nearest range finder: column memory, update logic, output queue.
// Depends on cnrf_pkg, the channel interfaces in cnrf_ifs.sv and cnrf_isqrt.
//
// The block takes one point per clock cycle, indefinitely, as long as results are taken
// at the same pace. Each point reads its column's entry from a single memory with one read
// and one write port, compares its squared distance in the second register stage and
// writes the entry back; a point of the same column right behind it takes the new entry
// from a forwarding register. A last-row point then passes a 17-stage square root pipeline
// and a 32-entry result queue, from which its result is offered. The input stalls only while
// 32 results are owed and not yet taken. The column memory needs no clearing: a column must
// see a first-row point before it is reported.
module column_nearest_range_finder_core #(
  parameter int MAX_COLUMNS = 1024,
  parameter int COORD_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cnrf_in_if.sink    in_ch,
  cnrf_out_if.source out_ch,
  cnrf_cfg_if.sink   cfg_ch
);

  localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int D2_W   = 2 * COORD_BITS;
  localparam int CMP_W  = (D2_W > cnrf_pkg::SQ_W) ? D2_W : cnrf_pkg::SQ_W;
  localparam int ZW     = (COORD_BITS > cnrf_pkg::RANGE_W) ? COORD_BITS : cnrf_pkg::RANGE_W;

  // Configuration registers and the squared range limits.
  logic [cnrf_pkg::RANGE_W-1:0]        rmin_r;
  logic [cnrf_pkg::RANGE_W-1:0]        rmax_r;
  logic signed [cnrf_pkg::RANGE_W-1:0] hmin_r;
  logic signed [cnrf_pkg::RANGE_W-1:0] hmax_r;
  logic [cnrf_pkg::SQ_W-1:0]           rmin2_r;
  logic [cnrf_pkg::SQ_W-1:0]           rmax2_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmin_r <= cnrf_pkg::RANGE_MIN_RST;
      rmax_r <= cnrf_pkg::RANGE_MAX_RST;
      hmin_r <= cnrf_pkg::HEIGHT_MIN_RST;
      hmax_r <= cnrf_pkg::HEIGHT_MAX_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        cnrf_pkg::REG_RANGE_MIN:  rmin_r <= cfg_ch.data;
        cnrf_pkg::REG_RANGE_MAX:  rmax_r <= cfg_ch.data;
        cnrf_pkg::REG_HEIGHT_MIN: hmin_r <= $signed(cfg_ch.data);
        cnrf_pkg::REG_HEIGHT_MAX: hmax_r <= $signed(cfg_ch.data);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rmin2_r <= rmin_r * rmin_r;
    rmax2_r <= rmax_r * rmax_r;
  end

  // Input transfer and result credits.
  logic                      in_acc;
  logic                      out_pop;
  logic [cnrf_pkg::CNT_W-1:0] cnt_r;
  logic [cnrf_pkg::CNT_W-1:0] cnt_nxt;

  assign in_ch.ready = cnt_r < cnrf_pkg::CNT_W'(cnrf_pkg::FIFO_DEPTH);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cnt_nxt     = cnt_r + cnrf_pkg::CNT_W'(in_acc && in_ch.last_row)
                       - cnrf_pkg::CNT_W'(out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // First stage: squares and the height test.
  logic signed [D2_W-1:0] xsq;
  logic signed [D2_W-1:0] ysq;
  logic signed [ZW-1:0]   z_e;
  logic signed [ZW-1:0]   hmin_e;
  logic signed [ZW-1:0]   hmax_e;

  assign xsq    = in_ch.point_x * in_ch.point_x;
  assign ysq    = in_ch.point_y * in_ch.point_y;
  assign z_e    = ZW'(in_ch.point_z);
  assign hmin_e = ZW'(hmin_r);
  assign hmax_e = ZW'(hmax_r);

  logic                       s1_vld_r;
  logic [D2_W-1:0]            xsq_r;
  logic [D2_W-1:0]            ysq_r;
  logic                       s1_zok_r;
  logic [cnrf_pkg::COL_W-1:0] s1_col_r;
  logic                       s1_first_r;
  logic                       s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
    xsq_r      <= unsigned'(xsq);
    ysq_r      <= unsigned'(ysq);
    s1_zok_r   <= (z_e > hmin_e) && (z_e < hmax_e);
    s1_col_r   <= in_ch.column_index;
    s1_first_r <= in_ch.first_row;
    s1_last_r  <= in_ch.last_row;
  end

  logic [cnrf_pkg::EXT_W-1:0] s1_col_e;
  logic [ADDR_W-1:0]          s1_addr;
  logic                       s1_inr;

  assign s1_col_e = cnrf_pkg::EXT_W'(s1_col_r);
  assign s1_addr  = s1_col_e[ADDR_W-1:0];
  assign s1_inr   = s1_col_e < cnrf_pkg::EXT_W'(MAX_COLUMNS);

  // Second stage: column memory read, compare, write back.
  cnrf_pkg::cnrf_entry_t col_mem [0:MAX_COLUMNS-1];
  cnrf_pkg::cnrf_entry_t rd_data_r;

  logic                       s2_vld_r;
  logic [D2_W-1:0]            d2_r;
  logic                       s2_zok_r;
  logic [cnrf_pkg::COL_W-1:0] s2_col_r;
  logic [ADDR_W-1:0]          s2_addr_r;
  logic                       s2_inr_r;
  logic                       s2_first_r;
  logic                       s2_last_r;

  logic                       wr_vld_r;
  logic [ADDR_W-1:0]          wr_addr_r;
  cnrf_pkg::cnrf_entry_t      wr_data_r;

  cnrf_pkg::cnrf_entry_t base;
  cnrf_pkg::cnrf_entry_t upd;
  logic [CMP_W-1:0]      d2_c;
  logic                  counts;
  logic                  mem_we;

  always_comb begin
    if (s2_first_r) begin
      base.min_sq = rmax2_r;
      base.found  = 1'b0;
    end else if (wr_vld_r && (wr_addr_r == s2_addr_r)) begin
      base = wr_data_r;
    end else begin
      base = rd_data_r;
    end
    d2_c   = CMP_W'(d2_r);
    counts = s2_zok_r && (d2_c > CMP_W'(rmin2_r)) && (d2_c < CMP_W'(rmax2_r))
             && (d2_c < CMP_W'(base.min_sq));
    upd    = base;
    if (counts) begin
      upd.min_sq = d2_c[cnrf_pkg::SQ_W-1:0];
      upd.found  = 1'b1;
    end
  end

  assign mem_we = s2_vld_r && s2_inr_r;

  always_ff @(posedge clk) begin
    rd_data_r <= col_mem[s1_addr];
    if (mem_we) begin
      col_mem[s2_addr_r] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
      wr_vld_r <= mem_we;
    end
    d2_r       <= xsq_r + ysq_r;
    s2_zok_r   <= s1_zok_r;
    s2_col_r   <= s1_col_r;
    s2_addr_r  <= s1_addr;
    s2_inr_r   <= s1_inr;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    wr_addr_r  <= s2_addr_r;
    wr_data_r  <= upd;
  end

  // Square root of the reported minimum.
  logic                         sq_in_vld;
  logic [cnrf_pkg::SQ_W-1:0]    sq_in_val;
  cnrf_pkg::cnrf_tag_t          sq_in_tag;
  logic                         sq_vld;
  logic [cnrf_pkg::RANGE_W-1:0] sq_root;
  cnrf_pkg::cnrf_tag_t          sq_tag;

  always_comb begin
    sq_in_vld       = s2_vld_r && s2_last_r;
    sq_in_tag.col   = s2_col_r;
    sq_in_tag.found = s2_inr_r && upd.found;
    sq_in_val       = sq_in_tag.found ? upd.min_sq : '0;
  end

  cnrf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_in_vld),
    .in_val   (sq_in_val),
    .in_tag   (sq_in_tag),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // Result queue.
  cnrf_pkg::cnrf_res_t          fifo_q [0:cnrf_pkg::FIFO_DEPTH-1];
  cnrf_pkg::cnrf_res_t          push_res;
  logic [cnrf_pkg::FIFO_AW-1:0] wp_r;
  logic [cnrf_pkg::FIFO_AW-1:0] rp_r;
  logic [cnrf_pkg::CNT_W-1:0]   fcnt_r;
  logic [cnrf_pkg::CNT_W-1:0]   fcnt_nxt;

  always_comb begin
    push_res.col         = sq_tag.col;
    push_res.range_mm    = sq_root;
    push_res.range_valid = sq_tag.found;
  end

  assign out_pop  = out_ch.valid && out_ch.ready;
  assign fcnt_nxt = fcnt_r + cnrf_pkg::CNT_W'(sq_vld) - cnrf_pkg::CNT_W'(out_pop);

  always_ff @(posedge clk) begin
    if (sq_vld) begin
      fifo_q[wp_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fcnt_r <= '0;
    end else begin
      if (sq_vld) begin
        wp_r <= wp_r + 1'b1;
      end
      if (out_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      fcnt_r <= fcnt_nxt;
    end
  end

  assign out_ch.valid       = fcnt_r != '0;
  assign out_ch.out_column  = fifo_q[rp_r].col;
  assign out_ch.range_mm    = fifo_q[rp_r].range_mm;
  assign out_ch.range_valid = fifo_q[rp_r].range_valid;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnrf_pkg::CNT_W'(cnrf_pkg::FIFO_DEPTH))
    else $error("result credit count exceeds queue depth");

  a_queue_covered: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= cnt_r)
    else $error("queued results exceed owed results");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld |-> (fcnt_r != cnrf_pkg::CNT_W'(cnrf_pkg::FIFO_DEPTH)))
    else $error("result queue written while full");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.range_valid) |-> (out_ch.range_mm == '0))
    else $error("invalid column reported with nonzero range");

endmodule

/* test/cnrf_range_checker.sv */
// Checker for the column nearest range finder: watches the point, result and register channels.
// Predicts each column's nearest range and compares every result transfer against it.
// Depends on cnrf_pkg and the channel interfaces in cnrf_ifs.sv.
module cnrf_range_checker #(
  parameter int MAX_COLUMNS = 1024,
  parameter int COORD_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  cnrf_in_if   in_mon,
  cnrf_out_if  out_mon,
  cnrf_cfg_if  cfg_mon,
  output int   mismatch_count,
  output int   results_owed
);

  logic [cnrf_pkg::RANGE_W-1:0]        lim_range_min;
  logic [cnrf_pkg::RANGE_W-1:0]        lim_range_max;
  logic signed [cnrf_pkg::RANGE_W-1:0] lim_height_min;
  logic signed [cnrf_pkg::RANGE_W-1:0] lim_height_max;
  bit [cnrf_pkg::SQ_W-1:0]             col_min_sq [MAX_COLUMNS];
  bit                                  col_found  [MAX_COLUMNS];
  cnrf_pkg::cnrf_res_t                 owed_ranges [$];
  int                                  miss_total;

  function automatic logic [cnrf_pkg::RANGE_W-1:0] floor_sqrt(input longint unsigned n);
    logic [cnrf_pkg::RANGE_W-1:0] root;
    longint unsigned              trial;
    root = '0;
    for (int b = cnrf_pkg::RANGE_W - 1; b >= 0; b--) begin
      trial = longint'(root) | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial[cnrf_pkg::RANGE_W-1:0];
      end
    end
    return root;
  endfunction

  task automatic check_result();
    cnrf_pkg::cnrf_res_t want;
    if (owed_ranges.size() == 0) begin
      miss_total++;
      if (miss_total <= 10) begin
        $display("unexpected result: column %0d range %0d valid %0d",
                 out_mon.out_column, out_mon.range_mm, out_mon.range_valid);
      end
    end else begin
      want = owed_ranges.pop_front();
      if (want.col !== out_mon.out_column || want.range_mm !== out_mon.range_mm ||
          want.range_valid !== out_mon.range_valid) begin
        miss_total++;
        if (miss_total <= 10) begin
          $display("mismatch: column exp %0d got %0d, range exp %0d got %0d, valid exp %0d got %0d",
                   want.col, out_mon.out_column, want.range_mm, out_mon.range_mm,
                   want.range_valid, out_mon.range_valid);
        end
      end
    end
  endtask

  task automatic track_point();
    longint                         px;
    longint                         py;
    logic signed [COORD_BITS-1:0]   pz;
    logic [cnrf_pkg::COL_W-1:0]     col;
    longint unsigned                dist_sq;
    longint unsigned                min_sq;
    longint unsigned                max_sq;
    cnrf_pkg::cnrf_res_t            res;
    px      = longint'(in_mon.point_x);
    py      = longint'(in_mon.point_y);
    pz      = in_mon.point_z;
    col     = in_mon.column_index;
    dist_sq = px * px + py * py;
    min_sq  = 64'(lim_range_min);
    min_sq  = min_sq * min_sq;
    max_sq  = 64'(lim_range_max);
    max_sq  = max_sq * max_sq;
    if (col < MAX_COLUMNS) begin
      if (in_mon.first_row) begin
        col_min_sq[col] = max_sq[cnrf_pkg::SQ_W-1:0];
        col_found[col]  = 1'b0;
      end
      if (pz > lim_height_min && pz < lim_height_max && dist_sq > min_sq &&
          dist_sq < max_sq && dist_sq < col_min_sq[col]) begin
        col_min_sq[col] = dist_sq[cnrf_pkg::SQ_W-1:0];
        col_found[col]  = 1'b1;
      end
    end
    if (in_mon.last_row) begin
      res.col = col;
      if (col < MAX_COLUMNS && col_found[col]) begin
        res.range_mm    = floor_sqrt(64'(col_min_sq[col]));
        res.range_valid = 1'b1;
      end else begin
        res.range_mm    = '0;
        res.range_valid = 1'b0;
      end
      owed_ranges.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_range_min  = cnrf_pkg::RANGE_MIN_RST;
      lim_range_max  = cnrf_pkg::RANGE_MAX_RST;
      lim_height_min = cnrf_pkg::HEIGHT_MIN_RST;
      lim_height_max = cnrf_pkg::HEIGHT_MAX_RST;
      owed_ranges.delete();
      miss_total = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        track_point();
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          cnrf_pkg::REG_RANGE_MIN:  lim_range_min  = cfg_mon.data;
          cnrf_pkg::REG_RANGE_MAX:  lim_range_max  = cfg_mon.data;
          cnrf_pkg::REG_HEIGHT_MIN: lim_height_min = cfg_mon.data;
          cnrf_pkg::REG_HEIGHT_MAX: lim_height_max = cfg_mon.data;
          default: ;
        endcase
      end
    end
    mismatch_count <= miss_total;
    results_owed   <= owed_ranges.size();
  end

endmodule

/* test/tb_top.sv */
// Top of the column nearest range finder testbench: clock, reset, point clouds and register writes.
// Instantiates the core and cnrf_range_checker; depends on cnrf_pkg and cnrf_ifs.sv.
module tb_top;

  localparam int MAX_COLUMNS   = 1024;
  localparam int COORD_BITS    = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_POINTS  = 80;
  localparam int BURST_POINTS  = 80;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT   = 2000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   owed;
  int   hold_requests;
  bit   no_idle;
  int   points_sent;
  int   cur_height_min;
  int   cur_height_max;
  bit   col_started [MAX_COLUMNS];

  cnrf_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  cnrf_out_if out_ch ();
  cnrf_cfg_if cfg_ch ();

  column_nearest_range_finder_core #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .COORD_BITS (COORD_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  cnrf_range_checker #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .COORD_BITS (COORD_BITS)
  ) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .mismatch_count(mismatches),
    .results_owed  (owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int served;
    int span;
    served = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (served < hold_requests) begin
        served++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        span = no_idle ? 1 : $urandom_range(1, 12);
        repeat (span) @(posedge clk);
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] rand_coord();
    int v;
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom;
    end else begin
      v = int'($urandom_range(0, 24000)) - 12000;
    end
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_height();
    int lo;
    int hi;
    int v;
    lo = cur_height_min - 100;
    hi = cur_height_max + 100;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom;
    end else if (lo >= hi) begin
      v = int'($urandom_range(0, 4000)) - 2000;
    end else begin
      v = lo + int'($urandom_range(0, hi - lo));
    end
    return v[COORD_BITS-1:0];
  endfunction

  task automatic send_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic [COORD_BITS-1:0] z,
                            input logic [cnrf_pkg::COL_W-1:0] col,
                            input bit is_first, input bit is_last);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.point_x      <= x;
    in_ch.point_y      <= y;
    in_ch.point_z      <= z;
    in_ch.column_index <= col;
    in_ch.first_row    <= is_first || !col_started[col];
    in_ch.last_row     <= is_last;
    in_ch.valid        <= 1'b1;
    col_started[col] = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    points_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cnrf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cnrf_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_limits(input int rmin, input int rmax, input int hmin, input int hmax);
    settle();
    write_reg(cnrf_pkg::REG_RANGE_MIN, rmin[cnrf_pkg::CFG_DATA_W-1:0]);
    write_reg(cnrf_pkg::REG_RANGE_MAX, rmax[cnrf_pkg::CFG_DATA_W-1:0]);
    write_reg(cnrf_pkg::REG_HEIGHT_MIN, hmin[cnrf_pkg::CFG_DATA_W-1:0]);
    write_reg(cnrf_pkg::REG_HEIGHT_MAX, hmax[cnrf_pkg::CFG_DATA_W-1:0]);
    cfg_ch.valid <= 1'b0;
    cur_height_min = hmin;
    cur_height_max = hmax;
  endtask

  task automatic send_cloud();
    int width;
    int height;
    int base;
    bit skip_first;
    width      = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
    height     = $urandom_range(1, 4);
    base       = $urandom_range(0, MAX_COLUMNS - 1);
    skip_first = ($urandom_range(0, 9) == 0);
    for (int r = 0; r < height; r++) begin
      for (int c = 0; c < width; c++) begin
        send_point(rand_coord(), rand_coord(), rand_height(),
                   cnrf_pkg::COL_W'((base + c) % MAX_COLUMNS),
                   r == 0 && !skip_first, r == height - 1);
      end
    end
  endtask

  task automatic send_noise();
    send_point(rand_coord(), rand_coord(), rand_height(),
               cnrf_pkg::COL_W'($urandom_range(0, MAX_COLUMNS - 1)),
               $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
  endtask

  initial begin
    int phase_end;
    int rmin;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.point_x      <= '0;
    in_ch.point_y      <= '0;
    in_ch.point_z      <= '0;
    in_ch.column_index <= '0;
    in_ch.first_row    <= 1'b0;
    in_ch.last_row     <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    hold_requests      <= 0;
    no_idle            <= 1'b0;
    points_sent    = 0;
    cur_height_min = int'(cnrf_pkg::HEIGHT_MIN_RST);
    cur_height_max = int'(cnrf_pkg::HEIGHT_MAX_RST);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(16'sd600, 16'sd0, 16'sd100, 10'd0, 1'b1, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd100, 10'd1, 1'b1, 1'b0);
    send_point(16'sd3000, -16'sd4000, 16'sd500, 10'd1, 1'b0, 1'b0);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 10'd1, 1'b0, 1'b1);
    send_point(16'sd500, 16'sd0, 16'sd100, 10'd2, 1'b1, 1'b1);
    send_point(16'sd10000, 16'sd0, 16'sd100, 10'd3, 1'b1, 1'b1);
    send_point(16'sd0, -16'sd9999, 16'sd999, 10'd4, 1'b1, 1'b1);
    send_point(16'sd700, 16'sd0, 16'sd50, 10'd5, 1'b1, 1'b1);
    send_point(16'sd700, 16'sd0, 16'sd1000, 10'd6, 1'b1, 1'b1);
    send_point(16'sd32767, 16'sd32767, 16'sd32767, 10'd1023, 1'b1, 1'b0);
    send_point(-16'sd701, 16'sd0, 16'sd51, 10'd1023, 1'b0, 1'b1);
    send_point(16'sd800, 16'sd0, 16'sd100, 10'd7, 1'b1, 1'b0);
    send_point(16'sd2000, 16'sd0, 16'sd100, 10'd7, 1'b1, 1'b1);
    send_point(16'sd1200, 16'sd1600, 16'sd200, 10'd8, 1'b1, 1'b0);
    send_point(16'sd3000, 16'sd0, 16'sd200, 10'd8, 1'b0, 1'b1);

    set_limits(0, 46341, -32768, 32767);
    send_point(16'sd32767, 16'sd32767, 16'sd0, 10'd9, 1'b1, 1'b1);
    send_point(-16'sd32768, -16'sd32768, -16'sd1, 10'd10, 1'b1, 1'b1);
    send_point(16'sd1, 16'sd0, 16'sd32767, 10'd11, 1'b1, 1'b1);
    send_point(16'sd1, 16'sd0, -16'sd32767, 10'd12, 1'b1, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd0, 10'd13, 1'b1, 1'b1);

    set_limits(3000, 2000, -100, 100);
    send_point(16'sd2500, 16'sd0, 16'sd0, 10'd14, 1'b1, 1'b1);
    set_limits(0, 46341, 100, -100);
    send_point(16'sd2500, 16'sd0, 16'sd0, 10'd15, 1'b1, 1'b1);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_limits(int'(cnrf_pkg::RANGE_MIN_RST), int'(cnrf_pkg::RANGE_MAX_RST),
                      int'(cnrf_pkg::HEIGHT_MIN_RST), int'(cnrf_pkg::HEIGHT_MAX_RST));
        1: set_limits(0, 46341, -32768, 32767);
        3: set_limits(46341, 46341, 32767, -32768);
        5: set_limits(0, 0, -32768, 32767);
        default: begin
          rmin = $urandom_range(0, 3000);
          set_limits(rmin, rmin + int'($urandom_range(1, 20000)),
                     -int'($urandom_range(0, 3000)), int'($urandom_range(1, 3000)));
        end
      endcase
      if (phase == RANDOM_PHASES - 1) begin
        no_idle <= 1'b1;
      end
      if (phase == 2) begin
        hold_requests <= hold_requests + 1;
        repeat (BURST_POINTS) begin
          send_point(rand_coord(), rand_coord(), rand_height(),
                     cnrf_pkg::COL_W'($urandom_range(0, MAX_COLUMNS - 1)), 1'b1, 1'b1);
        end
      end
      phase_end = points_sent + PHASE_POINTS;
      while (points_sent < phase_end) begin
        if ($urandom_range(0, 5) == 0) begin
          send_noise();
        end else begin
          send_cloud();
        end
      end
    end

    settle();
    if (mismatches == 0 && owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
